// ===== hdl/rtp_pkg.sv =====
package rtp_pkg;

	localparam int DATA_WIDTH    = 16;
	localparam int CORDIC_STAGES = 16;
	localparam int GUARD         = 6;

	// micro-rotations actually built (table has 32 entries)
	localparam int NUM_ITER = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

	// datapath width: input sign, negation headroom, guard bits, CORDIC growth
	localparam int XW = DATA_WIDTH + GUARD + 3;

	// angle accumulator: units of 2^-32 turn
	localparam int ZW = 32;

	localparam int INVK_W = 24;
	localparam logic [INVK_W-1:0] INVK_Q24 = 24'd10188014;

	// gain product, x taken without its sign bit (always positive there)
	localparam int PW = XW - 1 + INVK_W;
	localparam int MAG_SHIFT = GUARD + INVK_W;
	localparam logic [PW:0] MAG_RND = (PW + 1)'(64'd1 << (MAG_SHIFT - 1));

	localparam logic [ZW-1:0] HALF_TURN32 = 32'h8000_0000;
	localparam logic [ZW-1:0] ANG_RND = ZW'(64'd1 << (31 - DATA_WIDTH));

	localparam logic [DATA_WIDTH-1:0] QUARTER_TURN = DATA_WIDTH'(64'd1 << (DATA_WIDTH - 2));
	localparam logic [DATA_WIDTH-1:0] THREE_QUARTER_TURN =
		DATA_WIDTH'(64'd3 << (DATA_WIDTH - 2));

	localparam logic [ZW-1:0] ATAN_TURN32 [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	// one CORDIC pipeline slot; spec marks a zero real part with its fixed result
	typedef struct packed {
		logic                         vld;
		logic                         spec;
		logic [DATA_WIDTH-1:0]        spec_mag;
		logic [DATA_WIDTH-1:0]        spec_ang;
		logic signed [XW-1:0]         x;
		logic signed [XW-1:0]         y;
		logic [ZW-1:0]                z;
	} cordic_t;

endpackage

// ===== hdl/rect_to_polar_converter.sv =====
// Rectangular to polar conversion, unrolled CORDIC vectoring pipeline.
// Throughput: one point per clock; one register per micro-rotation, then gain multiply.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits; payload registers are not reset.
module rect_to_polar_converter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	// [15:0] real_part (signed), [31:16] imag_part (signed)
	input  logic [2*rtp_pkg::DATA_WIDTH-1:0] s_axis_tdata,
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [15:0] magnitude, [31:16] angle (65536 = full turn)
	output logic [2*rtp_pkg::DATA_WIDTH-1:0] m_axis_tdata
);
	import rtp_pkg::*;

	// global advance: output register empty or being drained this cycle
	logic en;

	// ---------------- input conditioning -------------------------------
	logic [DATA_WIDTH-1:0] re_in;
	logic [DATA_WIDTH-1:0] im_in;
	logic signed [XW-1:0]  xe;
	logic signed [XW-1:0]  ye;
	logic signed [XW-1:0]  xa;
	logic signed [XW-1:0]  ya;
	logic signed [XW-1:0]  y_abs;
	logic                  x_neg;
	logic                  x_zero;
	logic                  y_zero;
	cordic_t               pre;

	assign re_in = s_axis_tdata[DATA_WIDTH-1:0];
	assign im_in = s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

	assign xe = {{(XW-DATA_WIDTH){re_in[DATA_WIDTH-1]}}, re_in};
	assign ye = {{(XW-DATA_WIDTH){im_in[DATA_WIDTH-1]}}, im_in};

	assign x_neg  = xe[XW-1];
	assign x_zero = (xe == '0);
	assign y_zero = (ye == '0);

	// left half plane: rotate by a half turn first
	assign xa    = x_neg ? -xe : xe;
	assign ya    = x_neg ? -ye : ye;
	assign y_abs = ye[XW-1] ? -ye : ye;

	always_comb begin
		pre.vld  = s_axis_tvalid;
		pre.spec = x_zero;
		// imaginary axis and origin bypass the CORDIC result
		pre.spec_mag = y_abs[DATA_WIDTH-1:0];
		if (y_zero) begin
			pre.spec_ang = '0;
		end else if (ye[XW-1]) begin
			pre.spec_ang = THREE_QUARTER_TURN;
		end else begin
			pre.spec_ang = QUARTER_TURN;
		end
		pre.x = xa <<< GUARD;
		pre.y = ya <<< GUARD;
		pre.z = x_neg ? HALF_TURN32 : '0;
	end

	// ---------------- stage 1: input register ---------------------------
	cordic_t cor [NUM_ITER+1];

	logic                  vld_s1;
	cordic_t               pay_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pre.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= pre;
		end
	end

	always_comb begin
		cor[0]     = pay_s1;
		cor[0].vld = vld_s1;
	end

	// ---------------- micro-rotations, one register each ----------------
	for (genvar i = 0; i < NUM_ITER; i++) begin : g_iter
		rtp_cordic_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.shift  (5'(i)),
			.atan   (ATAN_TURN32[i]),
			.d      (cor[i]),
			.q      (cor[i+1])
		);
	end

	// ---------------- gain multiply and angle rounding ------------------
	logic                  vld_mul_s1;
	logic                  spec_mul_s1;
	logic [DATA_WIDTH-1:0] spec_mag_mul_s1;
	logic [PW-1:0]         prod_mul_s1;
	logic [DATA_WIDTH-1:0] ang_mul_s1;
	logic [ZW-1:0]         z_rnd;

	// round half up to the output angle width; wraps at a full turn
	assign z_rnd = cor[NUM_ITER].z + ANG_RND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_mul_s1 <= 1'b0;
		end else if (en) begin
			vld_mul_s1 <= cor[NUM_ITER].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_mul_s1     <= cor[NUM_ITER].spec;
			spec_mag_mul_s1 <= cor[NUM_ITER].spec_mag;
			prod_mul_s1     <= PW'(cor[NUM_ITER].x[XW-2:0]) * PW'(INVK_Q24);
			ang_mul_s1      <= cor[NUM_ITER].spec ? cor[NUM_ITER].spec_ang
				: z_rnd[ZW-1 -: DATA_WIDTH];
		end
	end

	// ---------------- output register ------------------------------------
	logic [PW:0]               mag_sum;
	logic [PW-MAG_SHIFT:0]     mag_full;
	logic [DATA_WIDTH-1:0]     mag_sat;
	logic                      out_vld_q;
	logic [2*DATA_WIDTH-1:0]   out_data_q;

	assign mag_sum  = {1'b0, prod_mul_s1} + MAG_RND;
	assign mag_full = mag_sum[PW:MAG_SHIFT];
	assign mag_sat  = (mag_full > (PW-MAG_SHIFT+1)'({DATA_WIDTH{1'b1}}))
		? {DATA_WIDTH{1'b1}} : mag_full[DATA_WIDTH-1:0];

	assign en = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_mul_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {ang_mul_s1, spec_mul_s1 ? spec_mag_mul_s1 : mag_sat};
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- checks ------------------------------------------------
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while output stalled");

	a_accept_enters_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> cor[0].vld)
		else $error("accepted point missing from first stage");

	a_cordic_x_positive: assert property (@(posedge clk) disable iff (!arst_n)
		cor[NUM_ITER].vld && !cor[NUM_ITER].spec |-> !cor[NUM_ITER].x[XW-1])
		else $error("CORDIC real part went negative");

	a_axis_angle: assert property (@(posedge clk) disable iff (!arst_n)
		vld_mul_s1 && spec_mul_s1 |-> (ang_mul_s1 == '0) ||
			(ang_mul_s1 == QUARTER_TURN) || (ang_mul_s1 == THREE_QUARTER_TURN))
		else $error("bad angle on imaginary axis");

endmodule

// ===== hdl/rtp_cordic_stage.sv =====
module rtp_cordic_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [4:0]       shift,
	input  logic [31:0]      atan,
	input  rtp_pkg::cordic_t d,
	output rtp_pkg::cordic_t q
);
	import rtp_pkg::*;

	logic                  vld_s1;
	logic                  spec_s1;
	logic [DATA_WIDTH-1:0] spec_mag_s1;
	logic [DATA_WIDTH-1:0] spec_ang_s1;
	logic signed [XW-1:0]  x_s1;
	logic signed [XW-1:0]  y_s1;
	logic [ZW-1:0]         z_s1;

	logic signed [XW-1:0]  dx;
	logic signed [XW-1:0]  dy;

	// arithmetic shifts round toward minus infinity
	assign dx = d.y >>> shift;
	assign dy = d.x >>> shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1     <= d.spec;
			spec_mag_s1 <= d.spec_mag;
			spec_ang_s1 <= d.spec_ang;
			if (!d.y[XW-1]) begin
				x_s1 <= d.x + dx;
				y_s1 <= d.y - dy;
				z_s1 <= d.z + atan;
			end else begin
				x_s1 <= d.x - dx;
				y_s1 <= d.y + dy;
				z_s1 <= d.z - atan;
			end
		end
	end

	assign q = '{vld: vld_s1, spec: spec_s1, spec_mag: spec_mag_s1,
		spec_ang: spec_ang_s1, x: x_s1, y: y_s1, z: z_s1};

endmodule

// ===== sim/rect_to_polar_converter_tb.sv =====
`timescale 1ns / 100ps

// One expected result with the point that caused it, kept for mismatch reports
typedef struct packed {
	logic [rtp_pkg::DATA_WIDTH-1:0] angle;
	logic [rtp_pkg::DATA_WIDTH-1:0] magnitude;
} polar_t;

typedef struct {
	logic signed [rtp_pkg::DATA_WIDTH-1:0] re;
	logic signed [rtp_pkg::DATA_WIDTH-1:0] im;
	polar_t                                polar;
} polar_expect_t;

class polar_scoreboard;
	localparam int DW        = rtp_pkg::DATA_WIDTH;
	localparam int FRAC      = 6;          // guard bits below the integer point
	localparam int ROTATIONS = (rtp_pkg::CORDIC_STAGES > 32) ? 32 : rtp_pkg::CORDIC_STAGES;
	localparam longint unsigned INV_GAIN_Q24 = 64'd10188014;
	localparam logic [31:0] TURN_QUARTER  = 32'h4000_0000;
	localparam logic [31:0] TURN_3QUARTER = 32'hC000_0000;
	localparam logic [31:0] TURN_HALF     = 32'h8000_0000;
	localparam logic [31:0] ATAN_TURN [32] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	polar_expect_t expected_q[$];
	int            mismatch_count;

	function new();
		mismatch_count = 0;
	endfunction

	// 32-bit turn -> DW-bit angle, round half up, wraps at a full turn
	function logic [DW-1:0] turn_to_angle(longint unsigned t);
		t = t & 64'hFFFF_FFFF;
		t = (t + (64'd1 << (31 - DW))) >> (32 - DW);
		return t[DW-1:0];
	endfunction

	function polar_t predict_polar(logic signed [DW-1:0] re, logic signed [DW-1:0] im);
		longint          x;
		longint          y;
		longint          z;
		longint          dx;
		longint          dy;
		longint unsigned mag;
		longint unsigned offset;
		polar_t          p;
		x      = re;
		y      = im;
		z      = 0;
		offset = 0;
		if (x == 0 && y == 0) begin
			p.magnitude = '0;
			p.angle     = '0;
			return p;
		end
		// imaginary axis: exact quarter turns, length is |im|
		if (x == 0) begin
			mag         = (y < 0) ? -y : y;
			p.magnitude = (mag > (64'd1 << DW) - 1) ? '1 : mag[DW-1:0];
			p.angle     = turn_to_angle((y > 0) ? TURN_QUARTER : TURN_3QUARTER);
			return p;
		end
		// left half plane: mirror through the origin, add half a turn
		if (x < 0) begin
			x      = -x;
			y      = -y;
			offset = TURN_HALF;
		end
		x = x * (64'sd1 << FRAC);
		y = y * (64'sd1 << FRAC);
		for (int i = 0; i < ROTATIONS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + longint'(ATAN_TURN[i]);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - longint'(ATAN_TURN[i]);
			end
		end
		mag = (unsigned'(x) * INV_GAIN_Q24 + (64'd1 << (FRAC + 23))) >> (FRAC + 24);
		p.magnitude = (mag > (64'd1 << DW) - 1) ? '1 : mag[DW-1:0];
		p.angle     = turn_to_angle(unsigned'(z) + offset);
		return p;
	endfunction

	function void note_point(logic [2*DW-1:0] tdata);
		polar_expect_t e;
		e.re    = tdata[DW-1:0];
		e.im    = tdata[2*DW-1:DW];
		e.polar = predict_polar(e.re, e.im);
		expected_q.push_back(e);
	endfunction

	function void check_polar(logic [2*DW-1:0] tdata);
		polar_t        got;
		polar_expect_t e;
		got = tdata;
		if (expected_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("ERROR: unexpected result transfer mag %0d ang %0d",
					got.magnitude, got.angle);
			return;
		end
		e = expected_q.pop_front();
		if (got.magnitude !== e.polar.magnitude || got.angle !== e.polar.angle) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("ERROR: point (%0d,%0d) expected mag %0d ang %0d, got mag %0d ang %0d",
					e.re, e.im, e.polar.magnitude, e.polar.angle,
					got.magnitude, got.angle);
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module rect_to_polar_converter_tb;
	localparam int DW           = rtp_pkg::DATA_WIDTH;
	localparam int PHASE_ITEMS  = 150;
	localparam int RX_HOLD_LEN  = 100;    // far longer than the pipeline depth
	localparam int DRAIN_CYCLES = 30;
	localparam int CYCLE_LIMIT  = 100000;
	localparam int NUM_DIRECTED = 24;

	// axis points, corners, octant diagonals, wrap just below a full turn
	localparam int DIR_RE [NUM_DIRECTED] = '{
		0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768, 32767,
		-32768, 1, -1, 1, -1, 32767, -32768, -32768, 1, -1, 3, -12345
	};
	localparam int DIR_IM [NUM_DIRECTED] = '{
		0, 1, -1, 32767, -32768, 0, 0, 0, 0, 32767, -32768, -32768,
		32767, 1, -1, -1, 1, -1, 1, -1, 32767, -32768, -4, 6789
	};
	localparam int CORNERS [5] = '{-32768, -1, 0, 1, 32767};

	logic          clk;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [2*DW-1:0] s_axis_tdata;     // [15:0] real_part, [31:16] imag_part
	logic          m_axis_tvalid;
	logic          m_axis_tready;
	logic [2*DW-1:0] m_axis_tdata;     // [15:0] magnitude, [31:16] angle

	polar_scoreboard sb;
	int              tx_idle_pct;
	int              rx_idle_pct;
	bit              rx_hold_req;
	int              cycle_count;

	rect_to_polar_converter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offers one point, with a random gap first; returns in the step of its transfer.
	// tvalid stays high into the next point unless a gap follows.
	task automatic send_point(input logic [DW-1:0] re, input logic [DW-1:0] im);
		int gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {im, re};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_point({im, re});
	endtask

	// Lowers tvalid and waits until every predicted result has come back
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, plus one long hold-off on request so the
	// pipeline backs up into the input.
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (rx_hold_req) begin
				hold_left   = RX_HOLD_LEN;
				rx_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_polar(m_axis_tdata);
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		logic [DW-1:0] re;
		logic [DW-1:0] im;
		sb            = new();
		tx_idle_pct   = 0;
		rx_idle_pct   = 0;
		rx_hold_req   = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed points, no idling on either side
		for (int k = 0; k < NUM_DIRECTED; k++)
			send_point(DW'(DIR_RE[k]), DW'(DIR_IM[k]));
		drain_results();

		// three idling patterns: receiver-heavy, sender-heavy, none
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 35;
					rx_idle_pct = 64;
				end
				1: begin
					tx_idle_pct = 64;
					rx_idle_pct = 35;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long output stall while points keep coming
				if (n == 40 && phase != 1)
					rx_hold_req = 1'b1;
				case ($urandom_range(9))
					5: begin    // near the origin
						re = DW'($urandom_range(16)) - DW'(8);
						im = DW'($urandom_range(16)) - DW'(8);
					end
					6: begin    // imaginary axis
						re = '0;
						im = DW'($urandom);
					end
					7: begin    // real axis
						re = DW'($urandom);
						im = '0;
					end
					8: begin    // corners and unit steps
						re = DW'(CORNERS[$urandom_range(4)]);
						im = DW'(CORNERS[$urandom_range(4)]);
					end
					9: begin    // shallow angles, close to the wrap point
						re = DW'($urandom);
						im = DW'($urandom_range(6)) - DW'(3);
					end
					default: begin
						re = DW'($urandom);
						im = DW'($urandom);
					end
				endcase
				send_point(re, im);
			end
			drain_results();
		end

		// let any stray result show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/rtp_pkg.sv
hdl/rtp_cordic_stage.sv
hdl/rect_to_polar_converter.sv
sim/rect_to_polar_converter_tb.sv
